/* rtl/chfa_pkg.sv */
`default_nettype none
package chfa_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int IN_W  = 16;
    localparam int XY_W  = 28;
    localparam int Z_W   = 26;
    localparam int ANG_W = 16;
    localparam int SUM_W = 18;
    localparam int RND_SHIFT = 8;

    localparam logic signed [Z_W-1:0]   HALF_TURN_FINE = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] HALF_TURN_OUT  = 16'sd23040;
    localparam logic signed [SUM_W-1:0] FULL_TURN_OUT  = 18'sd46080;
    localparam logic signed [IN_W-1:0]  DECL_RESET     = 16'sd1687;

    typedef struct packed {
        logic                   valid;
        logic                   zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cvec;

    function automatic logic signed [Z_W-1:0] atan_term(input int idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            0:  r = 26'sd1474560;
            1:  r = 26'sd870484;
            2:  r = 26'sd459940;
            3:  r = 26'sd233473;
            4:  r = 26'sd117189;
            5:  r = 26'sd58652;
            6:  r = 26'sd29333;
            7:  r = 26'sd14667;
            8:  r = 26'sd7334;
            9:  r = 26'sd3667;
            10: r = 26'sd1833;
            11: r = 26'sd917;
            12: r = 26'sd458;
            13: r = 26'sd229;
            14: r = 26'sd115;
            15: r = 26'sd57;
            16: r = 26'sd29;
            17: r = 26'sd14;
            18: r = 26'sd7;
            19: r = 26'sd4;
            20: r = 26'sd2;
            21: r = 26'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/chfa_pre.sv */
`default_nettype none
module chfa_pre
    import chfa_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic signed [IN_W-1:0] i_x_raw,
    input  wire logic signed [IN_W-1:0] i_y_raw,
    output t_cvec                       o_vec
);

    t_cvec n_vec;
    t_cvec r_vec;
    logic signed [XY_W-1:0] x_ext;
    logic signed [XY_W-1:0] y_ext;

    always_comb begin
        x_ext = {{(XY_W-IN_W-RND_SHIFT){i_x_raw[IN_W-1]}}, i_x_raw, {RND_SHIFT{1'b0}}};
        y_ext = {{(XY_W-IN_W-RND_SHIFT){i_y_raw[IN_W-1]}}, i_y_raw, {RND_SHIFT{1'b0}}};
        n_vec.valid = i_accept;
        n_vec.zero  = (i_x_raw == '0) && (i_y_raw == '0);
        if (i_x_raw[IN_W-1]) begin
            n_vec.x = -x_ext;
            n_vec.y = -y_ext;
            n_vec.z = i_y_raw[IN_W-1] ? -HALF_TURN_FINE : HALF_TURN_FINE;
        end else begin
            n_vec.x = x_ext;
            n_vec.y = y_ext;
            n_vec.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec.valid <= 1'b0;
        end else begin
            r_vec.valid <= n_vec.valid;
        end
        r_vec.zero <= n_vec.zero;
        r_vec.x    <= n_vec.x;
        r_vec.y    <= n_vec.y;
        r_vec.z    <= n_vec.z;
    end

    assign o_vec = r_vec;

endmodule
`default_nettype wire

/* rtl/chfa_stage.sv */
`default_nettype none
module chfa_stage
    import chfa_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cvec i_vec,
    output t_cvec      o_vec
);

    localparam logic signed [Z_W-1:0] ATAN_STEP = atan_term(STEP);

    t_cvec n_vec;
    t_cvec r_vec;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    always_comb begin
        xs = i_vec.x >>> STEP;
        ys = i_vec.y >>> STEP;
        n_vec.valid = i_vec.valid;
        n_vec.zero  = i_vec.zero;
        if (!i_vec.y[XY_W-1]) begin
            n_vec.x = i_vec.x + ys;
            n_vec.y = i_vec.y - xs;
            n_vec.z = i_vec.z + ATAN_STEP;
        end else begin
            n_vec.x = i_vec.x - ys;
            n_vec.y = i_vec.y + xs;
            n_vec.z = i_vec.z - ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec.valid <= 1'b0;
        end else begin
            r_vec.valid <= n_vec.valid;
        end
        r_vec.zero <= n_vec.zero;
        r_vec.x    <= n_vec.x;
        r_vec.y    <= n_vec.y;
        r_vec.z    <= n_vec.z;
    end

    assign o_vec = r_vec;

endmodule
`default_nettype wire

/* rtl/chfa_post.sv */
`default_nettype none
module chfa_post
    import chfa_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cvec                  i_vec,
    input  wire logic signed [IN_W-1:0] i_decl,
    output logic                        o_valid,
    output logic [ANG_W-1:0]            o_heading
);

    logic signed [Z_W:0]          z_rnd;
    logic signed [Z_W-RND_SHIFT:0] ang_full;
    logic signed [ANG_W-1:0]      n_ang;
    logic signed [ANG_W-1:0]      r_ang;
    logic                         r_a_valid;
    logic signed [SUM_W-1:0]      sum;
    logic signed [SUM_W-1:0]      n_head;
    logic [ANG_W-1:0]             r_head;
    logic                         r_b_valid;

    // round to 1/128 degree, clamp to a half turn
    always_comb begin
        z_rnd    = {i_vec.z[Z_W-1], i_vec.z} + (Z_W+1)'(1 << (RND_SHIFT - 1));
        ang_full = z_rnd[Z_W:RND_SHIFT];
        if (i_vec.zero) begin
            n_ang = '0;
        end else if (ang_full > (Z_W-RND_SHIFT+1)'(HALF_TURN_OUT)) begin
            n_ang = HALF_TURN_OUT;
        end else if (ang_full < -(Z_W-RND_SHIFT+1)'(HALF_TURN_OUT)) begin
            n_ang = -HALF_TURN_OUT;
        end else begin
            n_ang = ang_full[ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_vec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang <= n_ang;
    end

    // add declination, wrap once each way
    always_comb begin
        sum = SUM_W'(r_ang) + SUM_W'(i_decl);
        n_head = sum;
        if (sum < 0) begin
            n_head = sum + FULL_TURN_OUT;
        end
        if (n_head > FULL_TURN_OUT) begin
            n_head = n_head - FULL_TURN_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head[ANG_W-1:0];
    end

    assign o_valid   = r_b_valid;
    assign o_heading = r_head;

    a_zero_ang: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vec.valid && i_vec.zero) |=> (r_a_valid && r_ang == '0))
        else $error("zero vector did not give zero angle");

    a_ang_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_ang <= HALF_TURN_OUT && r_ang >= -HALF_TURN_OUT))
        else $error("angle outside half turn");

endmodule
`default_nettype wire

/* rtl/compass_heading_from_axes.sv */
`default_nettype none
// From start to o_valid: input register, CORDIC stages, angle and heading registers.
// Throughput: one sample every cycle; one pipeline stage per CORDIC rotation.
// busy is always low and the result strobe cannot be held off.
// Reset: synchronous, active low; clears all valid bits and loads declination 1687.
module compass_heading_from_axes
    import chfa_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic signed [IN_W-1:0] i_x_raw,
    input  wire logic signed [IN_W-1:0] i_y_raw,
    input  wire logic                   i_cfg_we,
    input  wire logic signed [IN_W-1:0] i_cfg_wdata,
    output logic                        o_valid,
    output logic [ANG_W-1:0]            o_heading
);

    localparam int LATENCY = CORDIC_STEPS + 3;

    logic                   accept;
    logic signed [IN_W-1:0] r_decl;
    t_cvec                  stage_vec [0:CORDIC_STEPS];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= DECL_RESET;
        end else if (i_cfg_we) begin
            r_decl <= i_cfg_wdata;
        end
    end

    chfa_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_x_raw (i_x_raw),
        .i_y_raw (i_y_raw),
        .o_vec   (stage_vec[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        chfa_stage #(
            .STEP(g)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vec  (stage_vec[g]),
            .o_vec  (stage_vec[g+1])
        );
    end

    chfa_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vec    (stage_vec[CORDIC_STEPS]),
        .i_decl   (r_decl),
        .o_valid  (o_valid),
        .o_heading(o_heading)
    );

    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without a matching start");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(r_decl) <= HALF_TURN_OUT && $past(r_decl) >= -HALF_TURN_OUT)
        |-> (o_heading <= ANG_W'(FULL_TURN_OUT)))
        else $error("heading above a full turn");

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
module testbench;
    import chfa_pkg::*;

    typedef enum logic [1:0] {ENT_SAMPLE, ENT_DECL, ENT_SETTLE} ent_kind_e;

    typedef struct {
        ent_kind_e              kind;
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        int                     idle_pct;
    } ent_t;

    localparam longint ATAN_FINE [24] = '{
        1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
        7334, 3667, 1833, 917, 458, 229, 115, 57,
        29, 14, 7, 4, 2, 1, 0, 0
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic signed [IN_W-1:0] i_x_raw = '0;
    logic signed [IN_W-1:0] i_y_raw = '0;
    logic                   i_cfg_we = 1'b0;
    logic signed [IN_W-1:0] i_cfg_wdata = '0;
    logic                   o_valid;
    logic [ANG_W-1:0]       o_heading;

    ent_t                   pend_q[$];
    logic [ANG_W-1:0]       heading_q[$];
    logic signed [IN_W-1:0] decl_cur = DECL_RESET;
    int                     gap_left = 0;
    int                     n_sent = 0;
    int                     n_recv = 0;
    int                     n_cfg = 0;
    int                     n_err = 0;

    compass_heading_from_axes uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_x_raw    (i_x_raw),
        .i_y_raw    (i_y_raw),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid    (o_valid),
        .o_heading  (o_heading)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [ANG_W-1:0] heading_predict(input logic signed [IN_W-1:0] xr,
                                                         input logic signed [IN_W-1:0] yr,
                                                         input logic signed [IN_W-1:0] decl);
        longint xv;
        longint yv;
        longint zv;
        longint xs;
        longint ys;
        longint ang;
        longint hd;
        longint term;
        xv = xr;
        yv = yr;
        zv = 0;
        if (xv != 0 || yv != 0) begin
            xv = xv * 256;
            yv = yv * 256;
            if (xv < 0) begin
                zv = (yv >= 0) ? longint'(HALF_TURN_FINE) : -longint'(HALF_TURN_FINE);
                xv = -xv;
                yv = -yv;
            end
            for (int k = 0; k < CORDIC_STEPS_DEF; k++) begin
                term = (k < 24) ? ATAN_FINE[k] : 0;
                xs = xv >>> k;
                ys = yv >>> k;
                if (yv >= 0) begin
                    xv = xv + ys;
                    yv = yv - xs;
                    zv = zv + term;
                end else begin
                    xv = xv - ys;
                    yv = yv + xs;
                    zv = zv - term;
                end
            end
        end
        ang = (zv + 128) >>> 8;
        if (ang > HALF_TURN_OUT) ang = HALF_TURN_OUT;
        if (ang < -longint'(HALF_TURN_OUT)) ang = -longint'(HALF_TURN_OUT);
        hd = ang + longint'(decl);
        if (hd < 0) hd = hd + FULL_TURN_OUT;
        if (hd > FULL_TURN_OUT) hd = hd - FULL_TURN_OUT;
        return hd[ANG_W-1:0];
    endfunction

    function automatic logic signed [IN_W-1:0] axis_pick();
        logic signed [IN_W-1:0] v;
        case ($urandom_range(9))
            5, 6:    v = IN_W'(int'($urandom_range(8)) - 4);
            7: begin
                case ($urandom_range(3))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    2:       v = 16'sh8001;
                    default: v = '0;
                endcase
            end
            8:       v = IN_W'(int'($urandom_range(255)) - 128);
            9:       v = ($urandom_range(1) != 0) ? IN_W'(32767 - int'($urandom_range(64)))
                                                  : IN_W'(-32768 + int'($urandom_range(64)));
            default: v = IN_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic add_sample(input logic signed [IN_W-1:0] xv,
                              input logic signed [IN_W-1:0] yv, input int pct);
        ent_t e;
        e.kind = ENT_SAMPLE;
        e.x = xv;
        e.y = yv;
        e.idle_pct = pct;
        pend_q.push_back(e);
    endtask

    task automatic add_ctrl(input ent_kind_e kind, input logic signed [IN_W-1:0] v);
        ent_t e;
        e.kind = kind;
        e.x = v;
        e.y = '0;
        e.idle_pct = 0;
        pend_q.push_back(e);
    endtask

    always @(posedge i_clk) begin : drive
        ent_t e;
        logic nxt_start;
        logic nxt_we;
        nxt_start = 1'b0;
        nxt_we = 1'b0;
        if (!i_rst_n) begin
            gap_left = 0;
            decl_cur = DECL_RESET;
        end else begin
            if (start && !busy) begin
                heading_q.push_back(heading_predict(i_x_raw, i_y_raw, decl_cur));
                n_sent++;
            end
            if (start && busy) begin
                nxt_start = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pend_q.size() > 0) begin
                e = pend_q[0];
                case (e.kind)
                    ENT_SAMPLE: begin
                        void'(pend_q.pop_front());
                        i_x_raw <= e.x;
                        i_y_raw <= e.y;
                        nxt_start = 1'b1;
                        if (int'($urandom_range(99)) < e.idle_pct)
                            gap_left = $urandom_range(5, 1);
                    end
                    ENT_DECL: begin
                        if (heading_q.size() == 0) begin
                            void'(pend_q.pop_front());
                            i_cfg_wdata <= e.x;
                            nxt_we = 1'b1;
                            decl_cur = e.x;
                            n_cfg++;
                        end
                    end
                    default: begin
                        if (heading_q.size() == 0) void'(pend_q.pop_front());
                    end
                endcase
            end
        end
        start <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    always @(posedge i_clk) begin : watch
        logic [ANG_W-1:0] exp_h;
        if (i_rst_n && o_valid) begin
            if (heading_q.size() == 0) begin
                $display("%0t: heading %0d with no transfer pending", $time, o_heading);
                n_err++;
            end else begin
                exp_h = heading_q.pop_front();
                n_recv++;
                if (o_heading !== exp_h) begin
                    $display("%0t: heading mismatch: expected %0d, actual %0d",
                             $time, exp_h, o_heading);
                    n_err++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stim
        logic signed [IN_W-1:0] corner_x [20];
        logic signed [IN_W-1:0] corner_y [20];
        logic signed [IN_W-1:0] decl_set [7];
        int                     idle_set [7];
        logic signed [IN_W-1:0] xv;
        logic signed [IN_W-1:0] yv;
        int                     settle_at;

        corner_x = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767,
                     -16'sd32768, 16'sd32767, -16'sd1, -16'sd1, 16'sd1, 16'sd0, -16'sd1,
                     16'sd1, -16'sd32768, -16'sd32768, -16'sd5, 16'sd1, -16'sd32767};
        corner_y = '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
                     16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd0, 16'sd1, 16'sd1,
                     -16'sd1, 16'sd1, -16'sd1, 16'sd0, 16'sd32767, -16'sd1};
        decl_set = '{16'sd23040, -16'sd23040, 16'sd0, 16'sd32767, -16'sd32768,
                     IN_W'(int'($urandom_range(46080)) - 23040), 16'sd1687};
        idle_set = '{30, 0, 50, 20, 70, 10, 0};

        for (int i = 0; i < 20; i++) add_sample(corner_x[i], corner_y[i], 25);
        add_ctrl(ENT_SETTLE, '0);

        for (int p = 0; p < 7; p++) begin
            add_ctrl(ENT_DECL, decl_set[p]);
            for (int i = 0; i < 8; i++) add_sample(corner_x[i + 12], corner_y[i + 12], idle_set[p]);
            settle_at = $urandom_range(90, 5);
            for (int i = 0; i < 97; i++) begin
                xv = axis_pick();
                yv = axis_pick();
                case ($urandom_range(19))
                    0, 1:    yv = '0;
                    2:       xv = '0;
                    default: ;
                endcase
                add_sample(xv, yv, idle_set[p]);
                if (i == settle_at) add_ctrl(ENT_SETTLE, '0);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || start || heading_q.size() != 0) @(posedge i_clk);
        repeat (CORDIC_STEPS_DEF + 10) @(posedge i_clk);

        if (heading_q.size() != 0) begin
            $display("%0t: %0d headings never arrived", $time, heading_q.size());
            n_err++;
        end
        $display("Checked %0d headings from %0d sample transfers", n_recv, n_sent);
        $display("Covered reset declination plus %0d written settings, extremes included",
                 n_cfg);
        if (n_err == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
